// ===== rtl/core/assert_macros.svh =====
// ============================================================================
// assert_macros.svh
// Shared concurrent assertion macros for the body dechunker RTL.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication or expression on every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/core/hbd_pkg.sv =====
// ============================================================================
// hbd_pkg
// Types, codes and widths shared by the body dechunker modules.
// ============================================================================
package hbd_pkg;

    // Width of the byte, chunk-size and accumulator counters
    localparam int COUNT_BITS = 32;
    localparam logic [COUNT_BITS-1:0] CNT_MASK = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] ACC_LIMIT = CNT_MASK >> 4;

    // Configuration register widths
    localparam int CLEN_BITS = 33;
    localparam int MAXB_BITS = 32;
    localparam int CFG_DATA_BITS = (CLEN_BITS > MAXB_BITS) ? CLEN_BITS : MAXB_BITS;
    localparam int CFG_ADDR_BITS = 1;

    // Compare width covering the counter plus one and both register values
    localparam int CMP_BITS = (COUNT_BITS + 1 > CLEN_BITS) ? COUNT_BITS + 1 : CLEN_BITS;

    // Register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_CONTENT_LENGTH = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MAX_BODY_SIZE  = 1'b1;

    // Register reset values
    localparam logic [CLEN_BITS-1:0] CLEN_RESET = {CLEN_BITS{1'b1}};
    localparam logic [MAXB_BITS-1:0] MAXB_RESET = MAXB_BITS'(1048576);

    // Characters and radix
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam int HEX_SHIFT = 4;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);

    // Result status codes
    typedef enum logic [1:0] {
        ST_PENDING = 2'd0,
        ST_DONE    = 2'd1,
        ST_BAD     = 2'd2,
        ST_LARGE   = 2'd3
    } status_t;

    // Chunked decoding phase
    typedef enum logic [4:0] {
        PH_SIZE    = 5'b00001,
        PH_SIZE_LF = 5'b00010,
        PH_DATA    = 5'b00100,
        PH_SKIP_A  = 5'b01000,
        PH_SKIP_B  = 5'b10000
    } phase_t;

    // Classified input word, as queued from front to back
    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_cr;
        logic       is_lf;
    } entry_t;

    // Configuration register values seen by the back end
    typedef struct packed {
        logic [CLEN_BITS-1:0] content_length;
        logic [MAXB_BITS-1:0] max_body_size;
    } cfg_t;

    // Queue status toward its producer and consumer
    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

endpackage

// ===== rtl/core/hbd_ifs.sv =====
// ============================================================================
// hbd_ifs
// Valid/ready channel interfaces for raw body bytes and decoded results.
// ============================================================================
interface hbd_in_if;
    import hbd_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface hbd_out_if;
    import hbd_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic [1:0] status;

    modport source (output valid, output payload_byte, output payload_valid,
                    output status, input ready);
    modport sink   (input valid, input payload_byte, input payload_valid,
                    input status, output ready);
endinterface

// ===== rtl/core/hbd_fifo.sv =====
// ============================================================================
// hbd_fifo
// Short register queue of classified words between front and back.
// ============================================================================
`include "assert_macros.svh"

module hbd_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  hbd_pkg::entry_t     wr_data,
    input  logic                pop,
    output hbd_pkg::entry_t     rd_data,
    output hbd_pkg::fifo_stat_t stat
);
    import hbd_pkg::*;

    entry_t                   mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_ptr_reg;
    logic [FIFO_PTR_BITS-1:0] wr_ptr_next;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_reg;
    logic [FIFO_PTR_BITS-1:0] rd_ptr_next;
    logic [FIFO_PTR_BITS:0]   count_reg;
    logic [FIFO_PTR_BITS:0]   count_next;

    // Advance pointers with wrap at the last slot
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_BITS'(FIFO_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data    = mem[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == (FIFO_PTR_BITS + 1)'(FIFO_DEPTH));

    `ASSERT_NEVER(a_no_push_full, clk, rst_n, push && stat.full && !pop, "push into full queue")
    `ASSERT_NEVER(a_no_pop_empty, clk, rst_n, pop && stat.empty, "pop from empty queue")

endmodule

// ===== rtl/core/hbd_front.sv =====
// ============================================================================
// hbd_front
// Accept raw body bytes and classify them as hex digit, CR or LF.
// ============================================================================
module hbd_front (
    input  logic                clk,
    input  logic                rst_n,
    hbd_in_if.sink              in_ch,
    input  hbd_pkg::fifo_stat_t stat,
    output logic                push,
    output hbd_pkg::entry_t     wr_data
);
    import hbd_pkg::*;

    logic       is_hex;
    logic [3:0] hex_val;
    logic       ready_reg;

    // Decode the hex value of the byte, either case
    always_comb
    begin
        is_hex  = 1'b0;
        hex_val = 4'd0;
        if (in_ch.data_byte >= "0" && in_ch.data_byte <= "9")
        begin
            is_hex  = 1'b1;
            hex_val = 4'(in_ch.data_byte - "0");
        end
        else if (in_ch.data_byte >= "a" && in_ch.data_byte <= "f")
        begin
            is_hex  = 1'b1;
            hex_val = 4'(in_ch.data_byte - "a" + 8'd10);
        end
        else if (in_ch.data_byte >= "A" && in_ch.data_byte <= "F")
        begin
            is_hex  = 1'b1;
            hex_val = 4'(in_ch.data_byte - "A" + 8'd10);
        end
    end

    // Hold ready low during reset so no word is taken before the queue is clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
        end
        else
        begin
            ready_reg <= 1'b1;
        end
    end

    assign in_ch.ready       = ready_reg && !stat.full;
    assign push              = in_ch.valid && in_ch.ready;
    assign wr_data.data_byte = in_ch.data_byte;
    assign wr_data.is_hex    = is_hex;
    assign wr_data.hex_val   = hex_val;
    assign wr_data.is_cr     = (in_ch.data_byte == CH_CR);
    assign wr_data.is_lf     = (in_ch.data_byte == CH_LF);

endmodule

// ===== rtl/core/hbd_back.sv =====
// ============================================================================
// hbd_back
// Run the length / chunked decoding state per word and register the result.
// ============================================================================
`include "assert_macros.svh"

module hbd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  hbd_pkg::cfg_t       cfg,
    input  hbd_pkg::fifo_stat_t stat,
    input  hbd_pkg::entry_t     rd_data,
    output logic                pop,
    hbd_out_if.source           out_ch
);
    import hbd_pkg::*;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [COUNT_BITS-1:0] chunk_reg;
    logic [COUNT_BITS-1:0] chunk_next;
    logic [COUNT_BITS-1:0] acc_reg;
    logic [COUNT_BITS-1:0] acc_next;
    logic                  ended_reg;
    logic                  ended_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    status_t               status_reg;
    status_t               status_next;
    logic                  out_valid_reg;
    logic [7:0]            out_byte_reg;
    logic                  out_pv_reg;
    status_t               out_status_reg;

    logic                  pv;
    logic                  ended_eff;
    logic [CMP_BITS-1:0]   count_inc;
    logic [CMP_BITS-1:0]   clen_ext;
    logic [CMP_BITS-1:0]   maxb_ext;
    logic                  count_top;
    logic                  over_max;
    logic [COUNT_BITS-1:0] chunk_dec;

    // Take a word when the output register is free or being drained
    assign pop = !stat.empty && (!out_valid_reg || out_ch.ready);

    assign count_inc = CMP_BITS'(count_reg) + 1'b1;
    assign clen_ext  = CMP_BITS'(cfg.content_length[CLEN_BITS-2:0]);
    assign maxb_ext  = CMP_BITS'(cfg.max_body_size);
    assign count_top = (count_reg == CNT_MASK);
    assign over_max  = count_top || (count_inc > maxb_ext);
    assign chunk_dec = chunk_reg - 1'b1;
    assign ended_eff = ended_reg || (phase_reg == PH_SIZE_LF);

    // Advance the decoding state for one word
    always_comb
    begin
        phase_next  = phase_reg;
        chunk_next  = chunk_reg;
        acc_next    = acc_reg;
        ended_next  = ended_reg;
        count_next  = count_reg;
        status_next = status_reg;
        pv          = 1'b0;
        if (status_reg == ST_PENDING)
        begin
            if (!cfg.content_length[CLEN_BITS-1])
            begin
                // Length mode: check overrun first, then the size limit
                if (count_top || (count_inc > clen_ext))
                begin
                    status_next = ST_BAD;
                end
                else if (over_max)
                begin
                    status_next = ST_LARGE;
                end
                else
                begin
                    pv         = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (count_inc == clen_ext)
                    begin
                        status_next = ST_DONE;
                    end
                end
            end
            else
            begin
                case (phase_reg)
                    PH_SIZE,
                    PH_SIZE_LF:
                    begin
                        if (phase_reg == PH_SIZE_LF && rd_data.is_lf)
                        begin
                            // End of size line: load the chunk length
                            chunk_next = acc_reg;
                            acc_next   = '0;
                            ended_next = 1'b0;
                            if (acc_reg == '0)
                            begin
                                status_next = ST_DONE;
                                phase_next  = PH_SIZE;
                            end
                            else
                            begin
                                phase_next = PH_DATA;
                            end
                        end
                        else if (rd_data.is_cr)
                        begin
                            ended_next = ended_eff;
                            phase_next = PH_SIZE_LF;
                        end
                        else
                        begin
                            ended_next = ended_eff || !rd_data.is_hex;
                            phase_next = PH_SIZE;
                            if (rd_data.is_hex && !ended_eff)
                            begin
                                // Saturate the size at the top counter value
                                if (acc_reg > ACC_LIMIT)
                                begin
                                    acc_next = CNT_MASK;
                                end
                                else
                                begin
                                    acc_next = {acc_reg[COUNT_BITS-HEX_SHIFT-1:0],
                                                rd_data.hex_val};
                                end
                            end
                        end
                    end
                    PH_DATA:
                    begin
                        if (over_max)
                        begin
                            status_next = ST_LARGE;
                        end
                        else
                        begin
                            pv         = 1'b1;
                            count_next = count_reg + 1'b1;
                            chunk_next = chunk_dec;
                            if (chunk_dec == '0)
                            begin
                                phase_next = PH_SKIP_A;
                            end
                        end
                    end
                    PH_SKIP_A:
                    begin
                        phase_next = PH_SKIP_B;
                    end
                    default:
                    begin
                        phase_next = PH_SIZE;
                    end
                endcase
            end
        end
    end

    // Update state on each word taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_SIZE;
            chunk_reg  <= '0;
            acc_reg    <= '0;
            ended_reg  <= 1'b0;
            count_reg  <= '0;
            status_reg <= ST_PENDING;
        end
        else if (pop)
        begin
            phase_reg  <= phase_next;
            chunk_reg  <= chunk_next;
            acc_reg    <= acc_next;
            ended_reg  <= ended_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    // Output register: load on pop, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_byte_reg   <= pv ? rd_data.data_byte : 8'd0;
            out_pv_reg     <= pv;
            out_status_reg <= status_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.payload_byte  = out_byte_reg;
    assign out_ch.payload_valid = out_pv_reg;
    assign out_ch.status        = out_status_reg;

    `ASSERT_CLK(a_status_sticky, clk, rst_n, (status_reg != ST_PENDING) |=> (status_reg == $past(status_reg)), "final status changed")
    `ASSERT_CLK(a_data_nonzero, clk, rst_n, (phase_reg == PH_DATA) |-> (chunk_reg != '0), "data phase with empty chunk")

endmodule

// ===== rtl/core/http_body_dechunker_top.sv =====
// ============================================================================
// http_body_dechunker_top
// Request-body decoder: length-checked pass-through or chunked decoding.
// ============================================================================
// One body byte enters per word on in_ch and one result word leaves per byte
// on out_ch, carrying the payload byte, its valid flag and the status. While
// out_ch accepts results, the block sustains one byte per clock: the front
// classifies each byte into a four-word queue, and the back end updates the
// decoding state and loads the output register on the same clock edge. When
// nothing stalls, a byte taken is registered in the queue, then popped by the
// back end into the output register, from which out_ch presents its result.
// That state update in the back end sets the rate. Write content_length
// (index 0, negative selects chunked mode) and max_body_size (index 1) only
// while no results are outstanding; a final status stays until reset.
module http_body_dechunker_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    hbd_in_if.sink                               in_ch,
    hbd_out_if.source                            out_ch,
    input  logic                                 cfg_we,
    input  logic [hbd_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
    input  logic [hbd_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);
    import hbd_pkg::*;

    logic [CLEN_BITS-1:0] clen_reg;
    logic [MAXB_BITS-1:0] maxb_reg;
    cfg_t                 cfg;
    fifo_stat_t           stat;
    logic                 push;
    logic                 pop;
    entry_t               wr_data;
    entry_t               rd_data;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clen_reg <= CLEN_RESET;
            maxb_reg <= MAXB_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_CONTENT_LENGTH: clen_reg <= cfg_wdata[CLEN_BITS-1:0];
                CFG_MAX_BODY_SIZE:  maxb_reg <= cfg_wdata[MAXB_BITS-1:0];
                default:            ;
            endcase
        end
    end

    assign cfg.content_length = clen_reg;
    assign cfg.max_body_size  = maxb_reg;

    hbd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .stat    (stat),
        .push    (push),
        .wr_data (wr_data)
    );

    hbd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_data),
        .pop     (pop),
        .rd_data (rd_data),
        .stat    (stat)
    );

    hbd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .stat    (stat),
        .rd_data (rd_data),
        .pop     (pop),
        .out_ch  (out_ch)
    );

endmodule
